[rtl/sscu_pkg.sv]
// Servo setpoint command unit: shared types, codes and reset constants.
// No dependencies; imported by every module of the block.
`default_nettype none

package sscu_pkg;

	localparam int unsigned SSCU_BUF_DEPTH = 8;

	localparam int unsigned DATA_W = 16;

	// command codes carried in tuser
	typedef enum logic [1:0] {
		CMD_SERIAL = 2'd0,
		CMD_DOWN   = 2'd1,
		CMD_UP     = 2'd2,
		CMD_TOGGLE = 2'd3
	} sscu_cmd_t;

	// compare_written codes
	typedef enum logic [1:0] {
		WR_NONE = 2'd0,
		WR_A    = 2'd1,
		WR_B    = 2'd2
	} sscu_wr_t;

	// configuration register indexes
	localparam logic [1:0] REG_STEP_SIZE   = 2'd0;
	localparam logic [1:0] REG_LOWER_LIMIT = 2'd1;
	localparam logic [1:0] REG_UPPER_LIMIT = 2'd2;

	localparam logic [7:0] TERM_CHAR   = 8'h5F;
	localparam logic [7:0] CHAN_A_CHAR = 8'h51;
	localparam logic [7:0] CHAN_B_CHAR = 8'h57;
	localparam logic [7:0] DIGIT_BASE  = 8'd48;

	localparam logic [DATA_W-1:0] DUTY_RST  = 16'd1000;
	localparam logic [DATA_W-1:0] STEP_RST  = 16'd100;
	localparam logic [DATA_W-1:0] LOWER_RST = 16'd700;
	localparam logic [DATA_W-1:0] UPPER_RST = 16'd3000;

	// setpoint load request from the serial buffer
	typedef struct packed {
		logic              load_a;
		logic              load_b;
		logic [DATA_W-1:0] value;
	} sscu_load_t;

endpackage

`default_nettype wire

[rtl/sscu_rx_buffer.sv]
// Serial command buffer: collects bytes, on the terminator decodes "Qdddd" / "Wdddd".
// Depends on sscu_pkg.
`default_nettype none

module sscu_rx_buffer
	import sscu_pkg::*;
#(
	parameter int unsigned BUF_DEPTH = SSCU_BUF_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] rx_byte,
	output sscu_load_t      load
);

	localparam int unsigned CNT_W = $clog2(BUF_DEPTH + 1);
	localparam int unsigned IDX_W = $clog2(BUF_DEPTH);

	logic [7:0]       store_q [BUF_DEPTH];
	logic [CNT_W-1:0] widx_q;
	logic             is_term;
	logic             has_room;
	logic [7:0]       eff [5];
	logic [15:0]      d1, d2, d3, d4;

	assign is_term  = (rx_byte == TERM_CHAR);
	assign has_room = (widx_q < CNT_W'(BUF_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q <= '0;
			for (int i = 0; i < BUF_DEPTH; i++) begin
				store_q[i] <= '0;
			end
		end else if (take) begin
			if (is_term) begin
				if (has_room) begin
					store_q[widx_q[IDX_W-1:0]] <= '0;
				end
				widx_q <= '0;
			end else if (has_room) begin
				store_q[widx_q[IDX_W-1:0]] <= rx_byte;
				widx_q <= widx_q + CNT_W'(1);
			end
		end
	end

	// the decode sees a zero at the write index, in place of the terminator's zero stored at the edge
	always_comb begin
		for (int k = 0; k < 5; k++) begin
			eff[k] = (widx_q == CNT_W'(k)) ? 8'd0 : store_q[k];
		end
	end

	assign d1 = {8'd0, eff[1]} - {8'd0, DIGIT_BASE};
	assign d2 = {8'd0, eff[2]} - {8'd0, DIGIT_BASE};
	assign d3 = {8'd0, eff[3]} - {8'd0, DIGIT_BASE};
	assign d4 = {8'd0, eff[4]} - {8'd0, DIGIT_BASE};

	always_comb begin
		load.value  = 16'(d1 * 16'd1000) + 16'(d2 * 16'd100) + 16'(d3 * 16'd10) + d4;
		load.load_a = take && is_term && (eff[0] == CHAN_A_CHAR);
		load.load_b = take && is_term && (eff[0] == CHAN_B_CHAR);
	end

endmodule

`default_nettype wire

[rtl/servo_setpoint_command_unit_top.sv]
// Servo setpoint command unit, top level: stream ports, config registers, setpoints.
// Depends on sscu_pkg and sscu_rx_buffer.
// An accepted item goes into the input register, then into the result register that drives
// m_axis_tvalid; while a result waits, the input register holds one more item, then stalls.
// Throughput: one item per cycle while the result register is free or m_axis_tready is high.
// Reset (arst_n low): setpoints 1000, channel A selected, buffer and index cleared,
// step 100, lower limit 700, upper limit 3000.
`default_nettype none

module servo_setpoint_command_unit_top
	import sscu_pkg::*;
#(
	parameter int unsigned BUF_DEPTH = SSCU_BUF_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [15:0] setpoint_a, [31:16] setpoint_b, [32] channel_selected,
	// [34:33] compare_written, [39:35] zero
	output logic [39:0]      m_axis_tdata,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic              valid_s1;
	sscu_cmd_t         cmd_s1;
	logic [7:0]        byte_s1;
	logic              advance;

	logic [DATA_W-1:0] step_q, lower_q, upper_q;
	logic [DATA_W-1:0] duty_a_q, duty_b_q;
	logic              sel_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_a_q, out_b_q;
	logic              out_sel_q;
	sscu_wr_t          out_wr_q;

	sscu_load_t        load;
	logic [DATA_W-1:0] cur, stepped;
	logic [DATA_W-1:0] duty_a_d, duty_b_d;
	logic              sel_d;
	sscu_wr_t          wr_d;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= sscu_cmd_t'(s_axis_tuser);
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_RST;
			lower_q <= LOWER_RST;
			upper_q <= UPPER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_SIZE:   step_q  <= cfg_data;
				REG_LOWER_LIMIT: lower_q <= cfg_data;
				REG_UPPER_LIMIT: upper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sscu_rx_buffer #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_rx_buffer (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (advance && (cmd_s1 == CMD_SERIAL)),
		.rx_byte(byte_s1),
		.load   (load)
	);

	assign cur = sel_q ? duty_b_q : duty_a_q;

	always_comb begin
		duty_a_d = duty_a_q;
		duty_b_d = duty_b_q;
		sel_d    = sel_q;
		wr_d     = WR_NONE;
		stepped  = cur;
		case (cmd_s1)
			CMD_SERIAL: begin
				if (load.load_a) begin
					duty_a_d = load.value;
					wr_d     = WR_A;
				end else if (load.load_b) begin
					duty_b_d = load.value;
					wr_d     = WR_B;
				end
			end
			CMD_DOWN, CMD_UP: begin
				if (cmd_s1 == CMD_DOWN) begin
					if (cur >= lower_q) stepped = cur - step_q;
				end else begin
					if (cur <= upper_q) stepped = cur + step_q;
				end
				// rewritten even when a limit blocks the step
				if (sel_q) begin
					duty_b_d = stepped;
					wr_d     = WR_B;
				end else begin
					duty_a_d = stepped;
					wr_d     = WR_A;
				end
			end
			CMD_TOGGLE: sel_d = !sel_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_a_q <= DUTY_RST;
			duty_b_q <= DUTY_RST;
			sel_q    <= 1'b0;
		end else if (advance) begin
			duty_a_q <= duty_a_d;
			duty_b_q <= duty_b_d;
			sel_q    <= sel_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_a_q   <= duty_a_d;
			out_b_q   <= duty_b_d;
			out_sel_q <= sel_d;
			out_wr_q  <= wr_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_wr_q, out_sel_q, out_b_q, out_a_q};

endmodule

`default_nettype wire
